[design/utli_pkg.sv]
// Shared types and constants for the uniform table linear interpolator.
`default_nettype none
package utli_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;

    localparam int XW   = 32;   // abscissa / ordinate width
    localparam int SW   = 31;   // step width
    localparam int PTSW = 11;   // points_in_use width
    localparam int IDXW = 10;   // entry_index port width
    localparam int DW   = 33;   // |x - x_start| and |dy| width
    localparam int QW   = 33;   // quotient width of both dividers
    localparam int PKW  = 33;   // |dy*k| width kept when not saturating

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_EVAL = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        REG_X_START = 2'd0,
        REG_X_STEP  = 2'd1,
        REG_POINTS  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        func_t            func;
        logic [IDXW-1:0]  idx;
        logic [XW-1:0]    value;
        logic             neg;
    } div1_pay_t;

    typedef struct packed {
        logic [XW-1:0]    y0;
        logic             dy_neg;
        logic             k_neg;
        logic             sat_pre;
        logic [PKW-1:0]   pk;
    } div2_pay_t;

endpackage
`default_nettype wire

[design/utli_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with sideband payload.
`default_nettype none
module utli_div
    import utli_pkg::*;
#(
    parameter int NW  = 33,
    parameter int WD  = 31,
    parameter int QBW = 33,
    parameter int PW  = 8
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           in_vld,
    input  wire logic [NW-1:0]  in_num,
    input  wire logic [WD-1:0]  divisor,
    input  wire logic [PW-1:0]  in_pay,
    output logic                out_vld,
    output logic [QBW-1:0]      out_quot,
    output logic [WD-1:0]       out_rem,
    output logic [PW-1:0]       out_pay
);

    logic            vld_reg  [0:QBW];
    logic [WD-1:0]   rem_reg  [0:QBW];
    logic [QBW-1:0]  num_reg  [0:QBW];
    logic [QBW-1:0]  quot_reg [0:QBW];
    logic [PW-1:0]   pay_reg  [0:QBW];

    logic [WD-1:0]   rem_next  [1:QBW];
    logic [QBW-1:0]  quot_next [1:QBW];

    always_comb begin
        for (int j = 0; j < QBW; j++) begin
            logic [WD:0] cand;
            logic        ge;
            cand = {rem_reg[j], num_reg[j][QBW-1]};
            ge   = (cand >= {1'b0, divisor});
            rem_next[j+1]  = ge ? WD'(cand - {1'b0, divisor}) : cand[WD-1:0];
            quot_next[j+1] = {quot_reg[j][QBW-2:0], ge};
        end
    end

    // dividend is known to be below divisor * 2^QBW, so the high part seeds the remainder
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j <= QBW; j++) vld_reg[j] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_vld;
            for (int j = 1; j <= QBW; j++) vld_reg[j] <= vld_reg[j-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= WD'(in_num >> QBW);
            num_reg[0]  <= in_num[QBW-1:0];
            quot_reg[0] <= '0;
            pay_reg[0]  <= in_pay;
            for (int j = 1; j <= QBW; j++) begin
                rem_reg[j]  <= rem_next[j];
                num_reg[j]  <= {num_reg[j-1][QBW-2:0], 1'b0};
                quot_reg[j] <= quot_next[j];
                pay_reg[j]  <= pay_reg[j-1];
            end
        end
    end

    assign out_vld  = vld_reg[QBW];
    assign out_quot = quot_reg[QBW];
    assign out_rem  = rem_reg[QBW];
    assign out_pay  = pay_reg[QBW];

endmodule
`default_nettype wire

[design/utli_table.sv]
// Sample memory: one write port, two registered read ports.
`default_nettype none
module utli_table
    import utli_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           en,
    input  wire logic                           we,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0] waddr,
    input  wire logic [XW-1:0]                  wdata,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0] raddr0,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0] raddr1,
    output logic [XW-1:0]                       rdata0,
    output logic [XW-1:0]                       rdata1
);

    logic [XW-1:0] mem [0:TABLE_DEPTH-1];
    logic [XW-1:0] rd0_reg;
    logic [XW-1:0] rd1_reg;

    always_ff @(posedge aclk) begin
        if (en && we) mem[waddr] <= wdata;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rd0_reg <= mem[raddr0];
            rd1_reg <= mem[raddr1];
        end
    end

    assign rdata0 = rd0_reg;
    assign rdata1 = rd1_reg;

endmodule
`default_nettype wire

[design/uniform_table_linear_interp_unit.sv]
// Top level: uniform-grid linear interpolator in signed fixed point.
//
// Input stream (s_*): tuser[0] selects load (0) or evaluate (1). A load writes
// entry_value into the sample table at entry_index and returns nothing; an
// evaluate returns one result on the m_* stream: y_value in tdata and the
// clip flag in tuser[0]. Every table entry in use must be loaded before it is
// read. Queries below or above the table extrapolate from the end segments.
// Configuration (x_start, x_step, points_in_use) is written by the user via the
// APB port (pready always high) only while no request is in flight, unchecked.
//
// Throughput: one request per cycle unless the receiver stalls. The path holds
// 74 register stages: an input stage, two dividers of 34 stages each (a load
// stage and one stage per quotient bit; segment search and the dy*rem/step
// fraction), four stages for segment, table access, slope and products, and
// the output register. The whole pipeline advances when the output register is
// empty or taken; while the receiver stalls, every stage holds and s_tready is
// low.
// Synchronous reset clears all valid bits and presets the configuration;
// the data registers and the sample table hold no defined contents after reset.
`default_nettype none
module uniform_table_linear_interp_unit
    import utli_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // tdata: entry_index[9:0], entry_value[41:10], x_query[73:42], zero pad
    input  wire logic [79:0] s_tdata,
    // tuser: func[0]
    input  wire logic [0:0]  s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: y_value[31:0]
    output logic [31:0]      m_tdata,
    // tuser: saturated[0]
    output logic [0:0]       m_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int AW = $clog2(TABLE_DEPTH);

    // ---------------- configuration ----------------
    logic [XW-1:0]   x_start_reg;
    logic [SW-1:0]   x_step_reg;
    logic [PTSW-1:0] points_reg;
    logic            cfg_we;
    cfg_reg_t        cfg_sel;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_sel = cfg_reg_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_start_reg <= '0;
            x_step_reg  <= SW'(65536);
            points_reg  <= PTSW'(2);
        end else if (cfg_we) begin
            case (cfg_sel)
                REG_X_START: x_start_reg <= pwdata;
                REG_X_STEP:  x_step_reg  <= pwdata[SW-1:0];
                REG_POINTS:  points_reg  <= pwdata[PTSW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            REG_X_START: prdata = x_start_reg;
            REG_X_STEP:  prdata = {1'b0, x_step_reg};
            REG_POINTS:  prdata = {21'b0, points_reg};
            default:     prdata = '0;
        endcase
    end

    logic [SW-1:0] step_eff;
    logic [31:0]   pts32;
    logic [31:0]   pts_c;
    logic [QW-1:0] seg_lim;

    assign step_eff = (x_step_reg == '0) ? SW'(1) : x_step_reg;
    assign pts32    = {21'b0, points_reg};
    always_comb begin
        if (pts32 < 32'd2)                    pts_c = 32'd2;
        else if (pts32 > 32'(TABLE_DEPTH))    pts_c = 32'(TABLE_DEPTH);
        else                                  pts_c = pts32;
    end
    assign seg_lim = QW'(pts_c - 32'd2);

    // ---------------- pipeline control ----------------
    logic en;
    logic out_vld_reg;
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    // ---------------- stage 0: offset from x_start ----------------
    logic            vld0_reg;
    div1_pay_t       pay0_reg;
    logic [DW-1:0]   mag0_reg;
    logic signed [DW-1:0] d_s;

    assign d_s = $signed({s_tdata[73], s_tdata[73:42]})
               - $signed({x_start_reg[XW-1], x_start_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn)  vld0_reg <= 1'b0;
        else if (en)   vld0_reg <= s_tvalid;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pay0_reg.func  <= func_t'(s_tuser[0]);
            pay0_reg.idx   <= s_tdata[9:0];
            pay0_reg.value <= s_tdata[41:10];
            pay0_reg.neg   <= d_s[DW-1];
            mag0_reg       <= d_s[DW-1] ? DW'(-d_s) : DW'(d_s);
        end
    end

    // ---------------- divider 1: |d| / step ----------------
    logic            vld1;
    logic [QW-1:0]   q1;
    logic [SW-1:0]   r1;
    logic [$bits(div1_pay_t)-1:0] pay1_raw;
    div1_pay_t       pay1;

    utli_div #(.NW(DW), .WD(SW), .QBW(QW), .PW($bits(div1_pay_t))) u_div_seg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (vld0_reg),
        .in_num   (mag0_reg),
        .divisor  (step_eff),
        .in_pay   (pay0_reg),
        .out_vld  (vld1),
        .out_quot (q1),
        .out_rem  (r1),
        .out_pay  (pay1_raw)
    );
    assign pay1 = div1_pay_t'(pay1_raw);

    // ---------------- stage A: segment, whole steps, remainder ----------------
    logic            vldA_reg;
    func_t           funcA_reg;
    logic [IDXW-1:0] idxA_reg;
    logic [XW-1:0]   valA_reg;
    logic [AW-1:0]   nA_reg, n1A_reg;
    logic [QW-1:0]   akA_reg;
    logic            knegA_reg;
    logic [SW-1:0]   remA_reg;

    logic [AW-1:0]   n_c;
    logic [QW-1:0]   ak_c;
    logic            kneg_c;
    logic [SW-1:0]   rem_c;

    // below range: floor of a negative quotient rounds one step further down
    always_comb begin
        if (pay1.neg) begin
            n_c    = '0;
            kneg_c = 1'b1;
            if (r1 == '0) begin
                ak_c  = q1;
                rem_c = '0;
            end else begin
                ak_c  = q1 + QW'(1);
                rem_c = step_eff - r1;
            end
        end else if (q1 > seg_lim) begin
            n_c    = AW'(seg_lim);
            kneg_c = 1'b0;
            ak_c   = q1 - seg_lim;
            rem_c  = r1;
        end else begin
            n_c    = AW'(q1);
            kneg_c = 1'b0;
            ak_c   = '0;
            rem_c  = r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)  vldA_reg <= 1'b0;
        else if (en)   vldA_reg <= vld1;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            funcA_reg <= pay1.func;
            idxA_reg  <= pay1.idx;
            valA_reg  <= pay1.value;
            nA_reg    <= n_c;
            n1A_reg   <= n_c + AW'(1);
            akA_reg   <= ak_c;
            knegA_reg <= kneg_c;
            remA_reg  <= rem_c;
        end
    end

    // ---------------- stage B: table access ----------------
    logic          tbl_we;
    logic [XW-1:0] y0_rd, y1_rd;

    assign tbl_we = vldA_reg && (funcA_reg == FUNC_LOAD)
                 && (32'(idxA_reg) < 32'(TABLE_DEPTH));

    utli_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
        .aclk   (aclk),
        .en     (en),
        .we     (tbl_we),
        .waddr  (AW'(idxA_reg)),
        .wdata  (valA_reg),
        .raddr0 (nA_reg),
        .raddr1 (n1A_reg),
        .rdata0 (y0_rd),
        .rdata1 (y1_rd)
    );

    logic          vldB_reg;
    logic [QW-1:0] akB_reg;
    logic          knegB_reg;
    logic [SW-1:0] remB_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)  vldB_reg <= 1'b0;
        else if (en)   vldB_reg <= vldA_reg && (funcA_reg == FUNC_EVAL);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            akB_reg   <= akA_reg;
            knegB_reg <= knegA_reg;
            remB_reg  <= remA_reg;
        end
    end

    // ---------------- stage C: slope ----------------
    logic signed [DW-1:0] dy_s;
    assign dy_s = $signed({y1_rd[XW-1], y1_rd}) - $signed({y0_rd[XW-1], y0_rd});

    logic          vldC_reg;
    logic [XW-1:0] y0C_reg;
    logic          dynegC_reg;
    logic [DW-1:0] adyC_reg;
    logic [QW-1:0] akC_reg;
    logic          knegC_reg;
    logic [SW-1:0] remC_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)  vldC_reg <= 1'b0;
        else if (en)   vldC_reg <= vldB_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y0C_reg    <= y0_rd;
            dynegC_reg <= dy_s[DW-1];
            adyC_reg   <= dy_s[DW-1] ? DW'(-dy_s) : DW'(dy_s);
            akC_reg    <= akB_reg;
            knegC_reg  <= knegB_reg;
            remC_reg   <= remB_reg;
        end
    end

    // ---------------- stage D: products ----------------
    logic          vldD_reg;
    logic [XW-1:0] y0D_reg;
    logic          dynegD_reg, knegD_reg;
    logic [63:0]   premD_reg;
    logic [49:0]   plo_reg;
    logic [48:0]   phi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)  vldD_reg <= 1'b0;
        else if (en)   vldD_reg <= vldC_reg;
    end

    // |dy*k| split by halves of k so each multiplier is at most 33 x 17 bits
    always_ff @(posedge aclk) begin
        if (en) begin
            y0D_reg    <= y0C_reg;
            dynegD_reg <= dynegC_reg;
            knegD_reg  <= knegC_reg;
            premD_reg  <= 64'(adyC_reg * remC_reg);
            plo_reg    <= 50'(adyC_reg * akC_reg[16:0]);
            phi_reg    <= 49'(adyC_reg * akC_reg[32:17]);
        end
    end

    logic [65:0] pk_c;
    div2_pay_t   pay2_in;

    assign pk_c = 66'(plo_reg) + (66'(phi_reg) << 17);
    always_comb begin
        pay2_in.y0      = y0D_reg;
        pay2_in.dy_neg  = dynegD_reg;
        pay2_in.k_neg   = knegD_reg;
        pay2_in.sat_pre = (pk_c >= 66'h2_0000_0000);
        pay2_in.pk      = pk_c[PKW-1:0];
    end

    // ---------------- divider 2: |dy*rem| / step ----------------
    logic          vld2;
    logic [QW-1:0] q2;
    logic [SW-1:0] r2;
    logic [$bits(div2_pay_t)-1:0] pay2_raw;
    div2_pay_t     pay2;

    utli_div #(.NW(64), .WD(SW), .QBW(QW), .PW($bits(div2_pay_t))) u_div_frac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (vldD_reg),
        .in_num   (premD_reg),
        .divisor  (step_eff),
        .in_pay   (pay2_in),
        .out_vld  (vld2),
        .out_quot (q2),
        .out_rem  (r2),
        .out_pay  (pay2_raw)
    );
    assign pay2 = div2_pay_t'(pay2_raw);

    // ---------------- output stage: sum and clip ----------------
    logic signed [35:0] t_s, dk_s, y_s;
    logic [XW-1:0]      y_c;
    logic               sat_c;

    always_comb begin
        if (pay2.dy_neg) t_s = -($signed({3'b0, q2}) + ((r2 != '0) ? 36'sd1 : 36'sd0));
        else             t_s = $signed({3'b0, q2});
        if (pay2.dy_neg ^ pay2.k_neg) dk_s = -$signed({3'b0, pay2.pk});
        else                          dk_s = $signed({3'b0, pay2.pk});
        y_s = $signed({{4{pay2.y0[XW-1]}}, pay2.y0}) + dk_s + t_s;
        if (pay2.sat_pre) begin
            sat_c = 1'b1;
            y_c   = (pay2.dy_neg != pay2.k_neg) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (y_s > 36'sh0_7FFF_FFFF) begin
            sat_c = 1'b1;
            y_c   = 32'h7FFF_FFFF;
        end else if (y_s < -36'sh0_8000_0000) begin
            sat_c = 1'b1;
            y_c   = 32'h8000_0000;
        end else begin
            sat_c = 1'b0;
            y_c   = y_s[XW-1:0];
        end
    end

    logic [XW-1:0] y_out_reg;
    logic          sat_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)  out_vld_reg <= 1'b0;
        else if (en)   out_vld_reg <= vld2;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y_out_reg   <= y_c;
            sat_out_reg <= sat_c;
        end
    end

    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = y_out_reg;
    assign m_tuser[0] = sat_out_reg;

    // ---------------- checks ----------------
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_sat_is_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 32'h7FFF_FFFF || m_tdata == 32'h8000_0000))
        else $error("clip flag set on a value off the rails");

    a_seg_rem_lt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        vld1 |-> (r1 < step_eff))
        else $error("segment divider remainder not below step");

    a_frac_rem_lt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        vld2 |-> (r2 < step_eff))
        else $error("fraction divider remainder not below step");

endmodule
`default_nettype wire
